/* sv/vfpe_pkg.sv */
// Shared types and constants for the voxel face panel extractor.
// No dependencies; imported by the core and by its checker.
package vfpe_pkg;

  // Grid limits per axis (defaults for the core parameters)
  localparam int unsigned MAX_X_DEF = 32;
  localparam int unsigned MAX_Y_DEF = 32;
  localparam int unsigned MAX_Z_DEF = 32;

  // Field widths
  localparam int unsigned IDX_W   = 5;
  localparam int unsigned SIZE_W  = 6;
  localparam int unsigned CELL_W  = 31;
  localparam int unsigned COORD_W = 32;
  localparam int unsigned LIM_W   = 9;   // holds any limit up to 256

  // Stream widths
  localparam int unsigned S_TDATA_W = 3 * IDX_W + 1 + 3 * COORD_W;  // 112
  localparam int unsigned M_TDATA_W = 3 * COORD_W;                  // 96
  localparam int unsigned M_TUSER_W = 3;

  // APB
  localparam int unsigned APB_AW = 4;
  localparam int unsigned APB_DW = 32;

  // Register reset values
  localparam logic [SIZE_W-1:0] SIZE_RST = SIZE_W'(32);
  localparam logic [CELL_W-1:0] CELL_RST = CELL_W'(65536);

  // Register indexes
  typedef enum logic [1:0] {
    REG_SIZE_X    = 2'd0,
    REG_SIZE_Y    = 2'd1,
    REG_SIZE_Z    = 2'd2,
    REG_CELL_SIZE = 2'd3
  } reg_idx_e;

  // Request kind carried on tuser
  typedef enum logic {
    REQ_LOAD  = 1'b0,
    REQ_QUERY = 1'b1
  } req_e;

  // Face normal axis codes
  typedef enum logic [1:0] {
    AXIS_X = 2'd0,
    AXIS_Y = 2'd1,
    AXIS_Z = 2'd2
  } axis_e;

endpackage

/* sv/voxel_face_panel_extractor_core.sv */
// Voxel face panel extractor: voxel occupancy/centre stores, query sequencer
// and one shared saturating adder for face centres. Depends on vfpe_pkg.
//
// Usage
//   Slave stream: one request per transfer. tuser = 0 loads a voxel
//   (occupancy and centre), tuser = 1 queries one voxel. Loads outside the
//   store are dropped. A load is written to the store at its accept.
//   Master stream: one face per transfer, in order -x,+x,-y,+y,-z,+z; tlast
//   marks the final face of a query. An empty or out-of-range voxel yields
//   no faces.
//   Sequence: a query reads the voxel and its three plus-side neighbours in
//   turn through the single memory read port, then emits its faces (3 to 6)
//   through the shared adder, one per cycle while the receiver does not
//   stall. tready on the slave side is low throughout a query.
//   Stalls: the face output is registered; a stalled receiver holds the
//   sequencer at its current face, and a new request may be accepted while
//   the final face still waits.
//   Reset: the occupancy store is cleared by a pass of one entry per cycle
//   over all 2**(AXW+AYW+AZW) entries, with the slave tready low. APB
//   writes are taken throughout.
module voxel_face_panel_extractor_core #(
  parameter int unsigned MAX_X = vfpe_pkg::MAX_X_DEF,
  parameter int unsigned MAX_Y = vfpe_pkg::MAX_Y_DEF,
  parameter int unsigned MAX_Z = vfpe_pkg::MAX_Z_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  // Requests: tdata = index_x, index_y, index_z, filled, centre_x/y/z
  input  logic                           s_axis_tvalid_i,
  output logic                           s_axis_tready_o,
  input  logic [vfpe_pkg::S_TDATA_W-1:0] s_axis_tdata_i,   // ix,iy,iz,filled,cx,cy,cz
  input  logic                           s_axis_tuser_i,   // req_type
  // Faces
  output logic                           m_axis_tvalid_o,
  input  logic                           m_axis_tready_i,
  output logic [vfpe_pkg::M_TDATA_W-1:0] m_axis_tdata_o,   // panel_x, panel_y, panel_z
  output logic [vfpe_pkg::M_TUSER_W-1:0] m_axis_tuser_o,   // normal_axis[1:0], positive_side
  output logic                           m_axis_tlast_o,   // last_face
  // APB configuration
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [vfpe_pkg::APB_AW-1:0]    paddr,
  input  logic [vfpe_pkg::APB_DW-1:0]    pwdata,
  output logic [vfpe_pkg::APB_DW-1:0]    prdata,
  output logic                           pready
);
  import vfpe_pkg::*;

  // Store geometry: index fields are 5 bits, so no axis needs more than 32
  localparam int unsigned XS     = (MAX_X < 32) ? MAX_X : 32;
  localparam int unsigned YS     = (MAX_Y < 32) ? MAX_Y : 32;
  localparam int unsigned ZS     = (MAX_Z < 32) ? MAX_Z : 32;
  localparam int unsigned AXW    = (XS > 1) ? $clog2(XS) : 1;
  localparam int unsigned AYW    = (YS > 1) ? $clog2(YS) : 1;
  localparam int unsigned AZW    = (ZS > 1) ? $clog2(ZS) : 1;
  localparam int unsigned ADDR_W = AXW + AYW + AZW;
  localparam int unsigned DEPTH  = 1 << ADDR_W;

  localparam logic [LIM_W-1:0] MAXX_L = LIM_W'(MAX_X);
  localparam logic [LIM_W-1:0] MAXY_L = LIM_W'(MAX_Y);
  localparam logic [LIM_W-1:0] MAXZ_L = LIM_W'(MAX_Z);

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_READ,
    ST_EMIT
  } state_e;

  // ---------------------------------------------------------------------
  // Configuration registers
  logic [SIZE_W-1:0] size_x_q, size_y_q, size_z_q;
  logic [CELL_W-1:0] cell_q;
  logic              cfg_we;
  reg_idx_e          cfg_idx;

  assign pready  = 1'b1;
  assign cfg_we  = psel && penable && pwrite;
  assign cfg_idx = reg_idx_e'(paddr[3:2]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      size_x_q <= SIZE_RST;
      size_y_q <= SIZE_RST;
      size_z_q <= SIZE_RST;
      cell_q   <= CELL_RST;
    end else if (cfg_we) begin
      unique case (cfg_idx)
        REG_SIZE_X:    size_x_q <= pwdata[SIZE_W-1:0];
        REG_SIZE_Y:    size_y_q <= pwdata[SIZE_W-1:0];
        REG_SIZE_Z:    size_z_q <= pwdata[SIZE_W-1:0];
        REG_CELL_SIZE: cell_q   <= pwdata[CELL_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    prdata = '0;
    unique case (cfg_idx)
      REG_SIZE_X:    prdata = APB_DW'(size_x_q);
      REG_SIZE_Y:    prdata = APB_DW'(size_y_q);
      REG_SIZE_Z:    prdata = APB_DW'(size_z_q);
      REG_CELL_SIZE: prdata = APB_DW'(cell_q);
      default:       prdata = '0;
    endcase
  end

  // Limits in use: min(size, MAX)
  logic [LIM_W-1:0] lim_x, lim_y, lim_z;
  assign lim_x = (LIM_W'(size_x_q) < MAXX_L) ? LIM_W'(size_x_q) : MAXX_L;
  assign lim_y = (LIM_W'(size_y_q) < MAXY_L) ? LIM_W'(size_y_q) : MAXY_L;
  assign lim_z = (LIM_W'(size_z_q) < MAXZ_L) ? LIM_W'(size_z_q) : MAXZ_L;

  // ---------------------------------------------------------------------
  // Request fields
  logic [IDX_W-1:0]          in_x, in_y, in_z;
  logic                      in_filled;
  logic [3*COORD_W-1:0]      in_centre;
  logic                      in_accept;
  logic                      in_load, load_ok;

  assign in_x      = s_axis_tdata_i[IDX_W-1:0];
  assign in_y      = s_axis_tdata_i[2*IDX_W-1:IDX_W];
  assign in_z      = s_axis_tdata_i[3*IDX_W-1:2*IDX_W];
  assign in_filled = s_axis_tdata_i[3*IDX_W];
  assign in_centre = s_axis_tdata_i[S_TDATA_W-1:3*IDX_W+1];

  assign in_accept = s_axis_tvalid_i && s_axis_tready_o;
  assign in_load   = (req_e'(s_axis_tuser_i) == REQ_LOAD);
  assign load_ok   = (LIM_W'(in_x) < MAXX_L) && (LIM_W'(in_y) < MAXY_L)
                  && (LIM_W'(in_z) < MAXZ_L);

  // ---------------------------------------------------------------------
  // Sequencer registers
  state_e             state_q, state_d;
  logic [1:0]         step_q, step_d;
  logic [IDX_W-1:0]   ix_q, iy_q, iz_q, ix_d, iy_d, iz_d;
  logic [COORD_W-1:0] cen_q [3];
  logic [COORD_W-1:0] cen_d [3];
  logic [1:0]         pos_q, pos_d;       // +x, +y face flags gathered so far
  logic [5:0]         rem_q, rem_d;       // faces still to emit, slot order
  logic [ADDR_W-1:0]  clr_q, clr_d;
  logic               m_valid_q, m_valid_d;
  logic [M_TDATA_W-1:0] m_data_q, m_data_d;
  logic [M_TUSER_W-1:0] m_user_q, m_user_d;
  logic               m_last_q, m_last_d;

  // Memories
  logic               occ_mem [DEPTH];
  logic [3*COORD_W-1:0] cen_mem [DEPTH];
  logic               occ_rd_q;
  logic [3*COORD_W-1:0] cen_rd_q;
  logic [ADDR_W-1:0]  rd_addr, wr_addr;
  logic               occ_we, cen_we, occ_wd;

  // Read address: own voxel on accept, then the three plus-side neighbours
  logic [IDX_W-1:0] nx, ny, nz;
  assign nx = ix_q + IDX_W'(1);
  assign ny = iy_q + IDX_W'(1);
  assign nz = iz_q + IDX_W'(1);

  always_comb begin
    rd_addr = {in_z[AZW-1:0], in_y[AYW-1:0], in_x[AXW-1:0]};
    if (state_q == ST_READ) begin
      case (step_q)
        2'd0:    rd_addr = {iz_q[AZW-1:0], iy_q[AYW-1:0], nx[AXW-1:0]};
        2'd1:    rd_addr = {iz_q[AZW-1:0], ny[AYW-1:0], ix_q[AXW-1:0]};
        default: rd_addr = {nz[AZW-1:0], iy_q[AYW-1:0], ix_q[AXW-1:0]};
      endcase
    end
  end

  // Write port: clearing pass, or a load at its accept
  assign cen_we  = in_accept && in_load && load_ok;
  assign occ_we  = cen_we || (state_q == ST_CLEAR);
  assign occ_wd  = (state_q == ST_CLEAR) ? 1'b0 : in_filled;
  assign wr_addr = (state_q == ST_CLEAR) ? clr_q
                 : {in_z[AZW-1:0], in_y[AYW-1:0], in_x[AXW-1:0]};

  always_ff @(posedge clk_i) begin
    if (occ_we) begin
      occ_mem[wr_addr] <= occ_wd;
    end
    occ_rd_q <= occ_mem[rd_addr];
  end

  always_ff @(posedge clk_i) begin
    if (cen_we) begin
      cen_mem[wr_addr] <= in_centre;
    end
    cen_rd_q <= cen_mem[rd_addr];
  end

  // ---------------------------------------------------------------------
  // Neighbour test for the axis whose read lands this step
  logic [IDX_W-1:0] nb_idx;
  logic [LIM_W-1:0] nb_lim;
  logic             nb_face;
  logic             in_range;

  always_comb begin
    case (step_q)
      2'd1:    begin nb_idx = ix_q; nb_lim = lim_x; end
      2'd2:    begin nb_idx = iy_q; nb_lim = lim_y; end
      default: begin nb_idx = iz_q; nb_lim = lim_z; end
    endcase
  end

  // A neighbour past index 31 lies outside the store and is always empty
  assign nb_face  = !((LIM_W'(nb_idx) + LIM_W'(1)) < nb_lim) || (&nb_idx) || !occ_rd_q;
  assign in_range = (LIM_W'(ix_q) < lim_x) && (LIM_W'(iy_q) < lim_y)
                 && (LIM_W'(iz_q) < lim_z);

  // ---------------------------------------------------------------------
  // Shared face unit: pick the next slot, add or subtract the half cell
  logic [2:0]         slot;
  logic [1:0]         f_axis;
  logic               f_side;
  logic [5:0]         rem_next;
  logic signed [COORD_W+1:0] f_sum;
  logic [COORD_W-1:0] f_sat;
  logic [COORD_W+1:0] half_ext;

  always_comb begin
    slot = 3'd5;
    for (int i = 5; i >= 0; i--) begin
      if (rem_q[i]) slot = 3'(i);
    end
  end

  assign f_axis   = slot[2:1];
  assign f_side   = slot[0];
  assign rem_next = rem_q & ~(6'b1 << slot);
  assign half_ext = (COORD_W+2)'(cell_q[CELL_W-1:1]);

  always_comb begin
    logic [COORD_W-1:0] c_sel;
    case (f_axis)
      AXIS_X:  c_sel = cen_q[0];
      AXIS_Y:  c_sel = cen_q[1];
      default: c_sel = cen_q[2];
    endcase
    f_sum = f_side ? ($signed({{2{c_sel[COORD_W-1]}}, c_sel}) + $signed(half_ext))
                   : ($signed({{2{c_sel[COORD_W-1]}}, c_sel}) - $signed(half_ext));
    if (f_sum[COORD_W+1:COORD_W-1] == 3'b000 || f_sum[COORD_W+1:COORD_W-1] == 3'b111) begin
      f_sat = f_sum[COORD_W-1:0];
    end else if (f_sum[COORD_W+1]) begin
      f_sat = {1'b1, {(COORD_W-1){1'b0}}};
    end else begin
      f_sat = {1'b0, {(COORD_W-1){1'b1}}};
    end
  end

  // ---------------------------------------------------------------------
  // Next-state logic
  always_comb begin
    logic [COORD_W-1:0] px, py, pz;
    state_d   = state_q;
    step_d    = step_q;
    ix_d      = ix_q;
    iy_d      = iy_q;
    iz_d      = iz_q;
    cen_d     = cen_q;
    pos_d     = pos_q;
    rem_d     = rem_q;
    clr_d     = clr_q;
    m_valid_d = m_valid_q && !m_axis_tready_i;
    m_data_d  = m_data_q;
    m_user_d  = m_user_q;
    m_last_d  = m_last_q;
    px        = cen_q[0];
    py        = cen_q[1];
    pz        = cen_q[2];

    unique case (state_q)
      ST_CLEAR: begin
        clr_d = clr_q + ADDR_W'(1);
        if (&clr_q) state_d = ST_IDLE;
      end

      ST_IDLE: begin
        if (in_accept && !in_load) begin
          ix_d    = in_x;
          iy_d    = in_y;
          iz_d    = in_z;
          step_d  = 2'd0;
          state_d = ST_READ;
        end
      end

      ST_READ: begin
        step_d = step_q + 2'd1;
        case (step_q)
          2'd0: begin
            // own voxel data has landed
            cen_d[0] = cen_rd_q[COORD_W-1:0];
            cen_d[1] = cen_rd_q[2*COORD_W-1:COORD_W];
            cen_d[2] = cen_rd_q[3*COORD_W-1:2*COORD_W];
            if (!(in_range && occ_rd_q)) state_d = ST_IDLE;
          end
          2'd1: pos_d[0] = nb_face;
          2'd2: pos_d[1] = nb_face;
          default: begin
            rem_d   = {nb_face, 1'b1, pos_q[1], 1'b1, pos_q[0], 1'b1};
            state_d = ST_EMIT;
          end
        endcase
      end

      ST_EMIT: begin
        if (!m_valid_q || m_axis_tready_i) begin
          case (f_axis)
            AXIS_X:  px = f_sat;
            AXIS_Y:  py = f_sat;
            default: pz = f_sat;
          endcase
          m_valid_d = 1'b1;
          m_data_d  = {pz, py, px};
          m_user_d  = {f_side, f_axis};
          m_last_d  = (rem_next == 6'd0);
          rem_d     = rem_next;
          if (rem_next == 6'd0) state_d = ST_IDLE;
        end
      end

      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_CLEAR;
      step_q    <= '0;
      ix_q      <= '0;
      iy_q      <= '0;
      iz_q      <= '0;
      cen_q     <= '{default: '0};
      pos_q     <= '0;
      rem_q     <= '0;
      clr_q     <= '0;
      m_valid_q <= 1'b0;
      m_data_q  <= '0;
      m_user_q  <= '0;
      m_last_q  <= 1'b0;
    end else begin
      state_q   <= state_d;
      step_q    <= step_d;
      ix_q      <= ix_d;
      iy_q      <= iy_d;
      iz_q      <= iz_d;
      cen_q     <= cen_d;
      pos_q     <= pos_d;
      rem_q     <= rem_d;
      clr_q     <= clr_d;
      m_valid_q <= m_valid_d;
      m_data_q  <= m_data_d;
      m_user_q  <= m_user_d;
      m_last_q  <= m_last_d;
    end
  end

  // Outputs
  assign s_axis_tready_o = (state_q == ST_IDLE);
  assign m_axis_tvalid_o = m_valid_q;
  assign m_axis_tdata_o  = m_data_q;
  assign m_axis_tuser_o  = m_user_q;
  assign m_axis_tlast_o  = m_last_q;

endmodule

/* sv/vfpe_checker.sv */
// Port-level checks for voxel_face_panel_extractor_core, bound to it below.
// Depends on vfpe_pkg.
module vfpe_checker (
  input logic                           clk_i,
  input logic                           rst_ni,
  input logic                           s_axis_tvalid_i,
  input logic                           s_axis_tready_o,
  input logic                           s_axis_tuser_i,
  input logic                           m_axis_tvalid_o,
  input logic                           m_axis_tready_i,
  input logic [vfpe_pkg::M_TDATA_W-1:0] m_axis_tdata_o,
  input logic [vfpe_pkg::M_TUSER_W-1:0] m_axis_tuser_o,
  input logic                           m_axis_tlast_o
);
  import vfpe_pkg::*;

  // A stalled face holds
  a_face_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=>
      m_axis_tvalid_o && $stable(m_axis_tdata_o) && $stable(m_axis_tuser_o)
      && $stable(m_axis_tlast_o))
    else $error("face changed while stalled");

  // Every query ends on a z face, since -z is always produced
  a_last_is_z: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && m_axis_tlast_o |-> m_axis_tuser_o[1:0] == AXIS_Z)
    else $error("final face of a query is not on the z axis");

  // Faces of one query follow back to back once one is taken
  a_faces_gapless: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && m_axis_tready_i && !m_axis_tlast_o |=> m_axis_tvalid_o)
    else $error("gap inside a query's faces");

  // A query always holds off the next request for its read phase
  a_query_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid_i && s_axis_tready_o && (s_axis_tuser_i == REQ_QUERY)
      |=> !s_axis_tready_o)
    else $error("request accepted during a query's read phase");

endmodule

bind voxel_face_panel_extractor_core vfpe_checker u_vfpe_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .s_axis_tvalid_i (s_axis_tvalid_i),
  .s_axis_tready_o (s_axis_tready_o),
  .s_axis_tuser_i  (s_axis_tuser_i),
  .m_axis_tvalid_o (m_axis_tvalid_o),
  .m_axis_tready_i (m_axis_tready_i),
  .m_axis_tdata_o  (m_axis_tdata_o),
  .m_axis_tuser_o  (m_axis_tuser_o),
  .m_axis_tlast_o  (m_axis_tlast_o)
);
